[hdl/utf8_stream_decoder_top_macros.svh]
// Assertion macros used by the checker file of the decoder.
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is high.
`define UTFD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is high.
`define UTFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/utfd_pkg.sv]
package utfd_pkg;

   localparam int ByteWidth = 8;
   localparam int CpWidth   = 21;
   localparam int PendWidth = 2;

   // Lead byte prefixes and the payload bits each one carries.
   localparam logic [2:0] LeadPfx2 = 3'b110;
   localparam logic [3:0] LeadPfx3 = 4'b1110;
   localparam logic [4:0] LeadPfx4 = 5'b11110;

   // Continuation bytes still expected after each kind of lead byte.
   localparam logic [PendWidth-1:0] PendNone = 2'd0;
   localparam logic [PendWidth-1:0] PendOne  = 2'd1;
   localparam logic [PendWidth-1:0] PendTwo  = 2'd2;
   localparam logic [PendWidth-1:0] PendThree = 2'd3;

   // Printable filter: everything from space upward, plus three control codes.
   localparam logic [CpWidth-1:0] CpMinPrint = 21'd32;
   localparam logic [CpWidth-1:0] CpTab      = 21'd9;
   localparam logic [CpWidth-1:0] CpLineFeed = 21'd10;
   localparam logic [CpWidth-1:0] CpCarRet   = 21'd13;

   // One accepted input transaction held in the input register.
   typedef struct packed {
      logic                 vld;
      logic [ByteWidth-1:0] data;
   } utfd_item_type;

   // What the decode logic hands to the output register.
   typedef struct packed {
      logic               emit;
      logic [CpWidth-1:0] cp;
   } utfd_result_type;

   function automatic logic utfd_printable(input logic [CpWidth-1:0] cp);
      return (cp >= CpMinPrint) || (cp == CpTab) || (cp == CpLineFeed) ||
             (cp == CpCarRet);
   endfunction

endpackage

[hdl/utfd_in_stage.sv]
module utfd_in_stage
   import utfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [ByteWidth-1:0] req_byte_in,
   output logic                 req_stall,
   input  logic                 out_free,
   output utfd_item_type        item
);

   logic                 vld_ff, vld_in;
   logic [ByteWidth-1:0] data_ff, data_in;

   // The register holds its byte only while the output side cannot take it.
   assign req_stall = vld_ff && !out_free;

   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      if (!req_stall) begin
         vld_in  = req_valid;
         data_in = req_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign item.vld  = vld_ff;
   assign item.data = data_ff;

endmodule

[hdl/utfd_decode.sv]
module utfd_decode
   import utfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  utfd_item_type   item,
   input  logic            out_free,
   output utfd_result_type result
);

   logic [PendWidth-1:0] pend_ff, pend_in;
   logic [CpWidth-1:0]   part_ff, part_in;
   logic [CpWidth-1:0]   acc;
   logic                 take;

   assign take = item.vld && out_free;

   // Shift the low six bits of the byte into the partial code point.
   assign acc = {part_ff[CpWidth-7:0], item.data[5:0]};

   // Classify the byte and step the sequence state.
   always_comb begin
      pend_in     = pend_ff;
      part_in     = part_ff;
      result.emit = 1'b0;
      result.cp   = acc;
      if (pend_ff != PendNone) begin
         if (item.data == '0) begin
            // A zero byte inside a sequence drops it.
            pend_in = PendNone;
            part_in = '0;
         end else if (pend_ff == PendOne) begin
            pend_in     = PendNone;
            part_in     = '0;
            result.emit = take && utfd_printable(acc);
         end else begin
            pend_in = pend_ff - PendOne;
            part_in = acc;
         end
      end else if (!item.data[7]) begin
         result.cp   = {{(CpWidth-ByteWidth){1'b0}}, item.data};
         result.emit = take && utfd_printable(result.cp);
      end else if (item.data[7:5] == LeadPfx2) begin
         pend_in = PendOne;
         part_in = {{(CpWidth-5){1'b0}}, item.data[4:0]};
      end else if (item.data[7:4] == LeadPfx3) begin
         pend_in = PendTwo;
         part_in = {{(CpWidth-4){1'b0}}, item.data[3:0]};
      end else if (item.data[7:3] == LeadPfx4) begin
         pend_in = PendThree;
         part_in = {{(CpWidth-3){1'b0}}, item.data[2:0]};
      end
      // Stray continuation bytes and bytes that start nothing fall through and leave the state alone.
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PendNone;
         part_ff <= '0;
      end else if (take) begin
         pend_ff <= pend_in;
         part_ff <= part_in;
      end
   end

endmodule

[hdl/utfd_out_stage.sv]
module utfd_out_stage
   import utfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  utfd_result_type    result,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [CpWidth-1:0] rsp_code_point,
   output logic               out_free
);

   logic               vld_ff, vld_in;
   logic [CpWidth-1:0] cp_ff, cp_in;

   // The register can load whenever it is empty or its transaction leaves now.
   assign out_free = !vld_ff || !rsp_stall;

   always_comb begin
      vld_in = vld_ff;
      cp_in  = cp_ff;
      if (out_free) begin
         vld_in = result.emit;
         cp_in  = result.cp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      cp_ff <= cp_in;
   end

   assign rsp_valid      = vld_ff;
   assign rsp_code_point = cp_ff;

endmodule

[hdl/utf8_stream_decoder_top.sv]
// Byte-serial UTF-8 decoder.
// The req channel carries one raw byte per transaction (req_byte_in); the
// rsp channel carries one decoded code point per transaction (rsp_code_point).
// Both channels use valid and stall: a transaction moves on a rising edge
// with valid high and stall low.
// Lead bytes start sequences of one to three continuation bytes; a code point
// goes out only when it is printable (32 and up, or tab, line feed, carriage
// return). Bytes that complete nothing give no rsp transaction.
// A byte accepted on req is held in the input register, decoded, and its code
// point is loaded into the output register, which drives rsp_valid.
// Throughput: one byte per cycle while rsp_stall holds no result, set by the
// single decode step between the input register and the output register.
// When rsp_stall holds a result, a byte can still enter the input register
// while it is empty; req_stall then rises until the result leaves.
// Synchronous reset clears both valid flags and the sequence state, so the
// decoder starts with no sequence pending.
module utf8_stream_decoder_top
   import utfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_byte_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CpWidth-1:0]   rsp_code_point
);

   utfd_item_type   item;
   utfd_result_type result;
   logic            out_free;

   utfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_byte_in (req_byte_in),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .item        (item)
   );

   utfd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .out_free (out_free),
      .result   (result)
   );

   utfd_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .result         (result),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_code_point (rsp_code_point),
      .out_free       (out_free)
   );

endmodule

[hdl/utfd_checker.sv]
`include "utf8_stream_decoder_top_macros.svh"

module utfd_checker
   import utfd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [ByteWidth-1:0] req_byte_in,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [CpWidth-1:0]   rsp_code_point
);

   // A stalled result stays offered with the same code point.
   `UTFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_code_point), "rsp transaction changed while stalled")

   // Only printable code points leave the block.
   `UTFD_ASSERT_IMPLY(a_rsp_printable, rsp_valid, (rsp_code_point >= CpMinPrint) || (rsp_code_point == CpTab) || (rsp_code_point == CpLineFeed) || (rsp_code_point == CpCarRet), "control code point on rsp")

   // The input side backs up only behind a stalled result.
   `UTFD_ASSERT_IMPLY(a_req_stall_cause, req_stall, rsp_valid && rsp_stall, "req_stall without a stalled rsp transaction")

endmodule

bind utf8_stream_decoder_top utfd_checker u_checker (.*);

[dv/utf8_stream_decoder_top_test.sv]
`timescale 1ns / 1ps

module utf8_stream_decoder_top_test
   import utfd_pkg::*;
();

   localparam int DirectedCount = 25;
   localparam int RandomBytes   = 950;

   // One row of the directed byte table. When fixed is set, the expected
   // outcome is typed into the row; otherwise the decode model supplies it.
   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 fixed;
      logic                 emit;
      logic [CpWidth-1:0]   point;
   } byte_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [ByteWidth-1:0] req_byte_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [CpWidth-1:0]   rsp_code_point;

   // Decode model state and the code points still owed by the decoder.
   logic [PendWidth-1:0] seq_left;
   logic [CpWidth-1:0]   seq_acc;
   logic [CpWidth-1:0]   owed_points[$];
   logic [CpWidth-1:0]   owed_point;
   int                   mismatch_count;
   int                   bytes_sent;
   byte_row_type         byte_table[DirectedCount];

   utf8_stream_decoder_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_in    (req_byte_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Decode one byte the way the decoder should: update the sequence state
   // and report whether a printable code point is completed.
   task automatic decode_byte(input logic [ByteWidth-1:0] b, output logic emit,
                              output logic [CpWidth-1:0] point);
      logic done;
      done  = 1'b0;
      emit  = 1'b0;
      point = '0;
      if (seq_left != PendNone) begin
         if (b == 8'h00) begin
            // A zero byte abandons the sequence in progress.
            seq_left = PendNone;
            seq_acc  = '0;
         end else begin
            // Any byte inside a sequence is taken as a continuation byte.
            seq_acc  = {seq_acc[CpWidth-7:0], b[5:0]};
            seq_left = seq_left - PendOne;
            if (seq_left == PendNone) begin
               point   = seq_acc;
               seq_acc = '0;
               done    = 1'b1;
            end
         end
      end else if (!b[7]) begin
         point = {{(CpWidth-ByteWidth){1'b0}}, b};
         done  = 1'b1;
      end else if (b[7:5] == LeadPfx2) begin
         seq_acc  = {{(CpWidth-5){1'b0}}, b[4:0]};
         seq_left = PendOne;
      end else if (b[7:4] == LeadPfx3) begin
         seq_acc  = {{(CpWidth-4){1'b0}}, b[3:0]};
         seq_left = PendTwo;
      end else if (b[7:3] == LeadPfx4) begin
         seq_acc  = {{(CpWidth-3){1'b0}}, b[2:0]};
         seq_left = PendThree;
      end
      // Control codes other than tab, line feed and carriage return are dropped.
      if (done)
         emit = (point >= CpMinPrint) || (point == CpTab) || (point == CpLineFeed) ||
                (point == CpCarRet);
   endtask

   // Mostly back to back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Send one byte transaction and record what it should produce once the
   // decoder has accepted it.
   task automatic send_byte(input logic [ByteWidth-1:0] b, input int gap,
                            input logic fixed, input logic fixed_emit,
                            input logic [CpWidth-1:0] fixed_point);
      logic               emit;
      logic [CpWidth-1:0] point;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b, emit, point);
      if (fixed) begin
         emit  = fixed_emit;
         point = fixed_point;
      end
      if (emit)
         owed_points.insert(owed_points.size(), point);
   endtask

   // Result side back pressure: quiet stretches, short stalls, a few long ones.
   initial begin
      int roll;
      rsp_stall = 1'b0;
      forever begin
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else if (roll < 58) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(60, 150)) @(posedge clock);
         end else if (roll < 95) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   // Compare every result transaction with the oldest owed code point.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_points.size() == 0) begin
            $error("rsp_code_point: expected no transaction, actual 0x%06h",
                   rsp_code_point);
            mismatch_count++;
         end else begin
            owed_point = owed_points.pop_front();
            if (rsp_code_point !== owed_point) begin
               $error("rsp_code_point: expected 0x%06h, actual 0x%06h",
                      owed_point, rsp_code_point);
               mismatch_count++;
            end
         end
      end
   end

   // Hard limit on the run time.
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [ByteWidth-1:0] seq_bytes[$];
      logic [ByteWidth-1:0] lead;
      int                   kind;
      int                   conts;
      int                   kept;
      bit                   calm;
      int                   calm_left;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_byte_in    = '0;
      seq_left       = PendNone;
      seq_acc        = '0;
      mismatch_count = 0;
      bytes_sent     = 0;
      calm           = 1'b0;
      calm_left      = 0;

      // Extremes, the printable filter, stray bytes, each sequence
      // length, a dropped sequence and a plain byte inside a sequence.
      byte_table = '{
         '{8'h41, 1'b1, 1'b1, 21'h000041},
         '{8'h00, 1'b1, 1'b0, 21'h000000},
         '{8'h7F, 1'b1, 1'b1, 21'h00007F},
         '{8'h09, 1'b1, 1'b1, 21'h000009},
         '{8'h0A, 1'b1, 1'b1, 21'h00000A},
         '{8'h0D, 1'b1, 1'b1, 21'h00000D},
         '{8'h1F, 1'b1, 1'b0, 21'h000000},
         '{8'h80, 1'b1, 1'b0, 21'h000000},
         '{8'hFF, 1'b1, 1'b0, 21'h000000},
         '{8'hC3, 1'b0, 1'b0, 21'h000000},
         '{8'hA9, 1'b0, 1'b0, 21'h000000},
         '{8'hC0, 1'b0, 1'b0, 21'h000000},
         '{8'h80, 1'b0, 1'b0, 21'h000000},
         '{8'hE2, 1'b0, 1'b0, 21'h000000},
         '{8'h82, 1'b0, 1'b0, 21'h000000},
         '{8'hAC, 1'b0, 1'b0, 21'h000000},
         '{8'hF7, 1'b0, 1'b0, 21'h000000},
         '{8'hBF, 1'b0, 1'b0, 21'h000000},
         '{8'hBF, 1'b0, 1'b0, 21'h000000},
         '{8'hBF, 1'b1, 1'b1, 21'h1FFFFF},
         '{8'hE1, 1'b0, 1'b0, 21'h000000},
         '{8'h00, 1'b0, 1'b0, 21'h000000},
         '{8'h41, 1'b1, 1'b1, 21'h000041},
         '{8'hDF, 1'b0, 1'b0, 21'h000000},
         '{8'h41, 1'b0, 1'b0, 21'h000000}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DirectedCount; i++)
         send_byte(byte_table[i].data, pick_gap(), byte_table[i].fixed,
                   byte_table[i].emit, byte_table[i].point);

      // Random part: mostly well-formed characters with random payloads,
      // the rest stray bytes and sequences cut short.
      while (bytes_sent < RandomBytes) begin
         seq_bytes.delete();
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            seq_bytes.insert(seq_bytes.size(), 8'($urandom_range(0, 127)));
         end else if (kind < 80) begin
            conts = (kind < 45) ? 1 : (kind < 65) ? 2 : 3;
            lead  = 8'($urandom_range(0, 255));
            case (conts)
               1: lead[7:5] = LeadPfx2;
               2: lead[7:4] = LeadPfx3;
               default: lead[7:3] = LeadPfx4;
            endcase
            seq_bytes.insert(seq_bytes.size(), lead);
            for (int k = 0; k < conts; k++)
               seq_bytes.insert(seq_bytes.size(), {2'b10, 6'($urandom_range(0, 63))});
         end else if (kind < 90) begin
            seq_bytes.insert(seq_bytes.size(), 8'($urandom_range(0, 255)));
         end else begin
            // A sequence that breaks off with a zero byte or a foreign byte.
            conts = $urandom_range(1, 3);
            lead  = 8'($urandom_range(0, 255));
            case (conts)
               1: lead[7:5] = LeadPfx2;
               2: lead[7:4] = LeadPfx3;
               default: lead[7:3] = LeadPfx4;
            endcase
            seq_bytes.insert(seq_bytes.size(), lead);
            kept = $urandom_range(0, conts - 1);
            for (int k = 0; k < kept; k++)
               seq_bytes.insert(seq_bytes.size(), {2'b10, 6'($urandom_range(0, 63))});
            if ($urandom_range(0, 1) == 0)
               seq_bytes.insert(seq_bytes.size(), 8'h00);
            else
               seq_bytes.insert(seq_bytes.size(), 8'($urandom_range(0, 255)));
         end

         foreach (seq_bytes[k]) begin
            // Now and then run a stretch of back-to-back transactions.
            if (calm_left == 0) begin
               calm      = ($urandom_range(0, 9) == 0);
               calm_left = $urandom_range(20, 80);
            end
            calm_left--;
            send_byte(seq_bytes[k], calm ? 0 : pick_gap(), 1'b0, 1'b0, '0);
         end
         bytes_sent += seq_bytes.size();
      end
      req_valid <= 1'b0;

      // Drain the owed results, then watch a while for stray ones.
      while (owed_points.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/utfd_pkg.sv
hdl/utfd_in_stage.sv
hdl/utfd_decode.sv
hdl/utfd_out_stage.sv
hdl/utf8_stream_decoder_top.sv
hdl/utfd_checker.sv
dv/utf8_stream_decoder_top_test.sv
